// ===== hdl/cst_pkg.sv =====
// Shared types, constants and character-class functions for the token scanner.
`default_nettype none
package cst_pkg;

  localparam int POS_BITS = 32;
  localparam int LEN_BITS = 16;
  localparam int START_BITS = 32;
  localparam int TLEN_BITS = 16;
  localparam int RES_SLOTS = 3;
  localparam int KW_COUNT = 6;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_NUM,
    MODE_WORD,
    MODE_STR,
    MODE_DROP
  } cst_mode_t;

  typedef enum logic [2:0] {
    KIND_KEYWORD,
    KIND_NUMBER,
    KIND_OPERATOR,
    KIND_PUNCT,
    KIND_STRING,
    KIND_END,
    KIND_ERROR
  } cst_kind_t;

  localparam logic [7:0] ERR_NUM_ALPHA = 8'd0;
  localparam logic [7:0] ERR_BAD_WORD = 8'd1;
  localparam logic [7:0] ERR_OPEN_STRING = 8'd2;
  localparam logic [7:0] ERR_BAD_CHAR = 8'd3;

  localparam logic [7:0] KW_TEXT [KW_COUNT][6] = '{
    '{"i", "n", "t", 8'h00, 8'h00, 8'h00},
    '{"r", "e", "t", "u", "r", "n"},
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "l", "s", "e", 8'h00, 8'h00},
    '{"w", "h", "i", "l", "e", 8'h00},
    '{"f", "o", "r", 8'h00, 8'h00, 8'h00}
  };
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd3, 3'd6, 3'd2, 3'd4, 3'd5, 3'd3};

  typedef struct packed {
    cst_kind_t              kind;
    logic [7:0]             detail;
    logic [START_BITS-1:0]  start_offset;
    logic [TLEN_BITS-1:0]   token_length;
  } cst_result_t;

  typedef struct packed {
    logic [1:0]  cnt;
    cst_result_t [RES_SLOTS-1:0] res;
  } cst_bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } cst_q_stat_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] idx;
  } cst_kw_hit_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_word_start(logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  endfunction

  function automatic logic is_word_char(logic [7:0] c);
    return is_word_start(c) || is_digit(c);
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic is_op(logic [7:0] c);
    return (c == "+") || (c == "-") || (c == "*") || (c == "/") || (c == "=") ||
           (c == "<") || (c == ">");
  endfunction

  function automatic logic is_punct(logic [7:0] c);
    return (c == ";") || (c == ",") || (c == "(") || (c == ")");
  endfunction

  function automatic logic [LEN_BITS-1:0] sat_inc(logic [LEN_BITS-1:0] v);
    return (v == {LEN_BITS{1'b1}}) ? v : v + LEN_BITS'(1);
  endfunction

  function automatic logic [KW_COUNT-1:0] kw_match(logic [KW_COUNT-1:0] cand,
                                                   logic [LEN_BITS-1:0] len,
                                                   logic [7:0] c);
    logic [KW_COUNT-1:0] r;
    r = cand;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (len >= LEN_BITS'(KW_LEN[k])) begin
        r[k] = 1'b0;
      end else if (KW_TEXT[k][len[2:0]] != c) begin
        r[k] = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic cst_kw_hit_t kw_close(logic [KW_COUNT-1:0] cand,
                                           logic [LEN_BITS-1:0] len);
    cst_kw_hit_t h;
    h = '0;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (cand[k] && (len == LEN_BITS'(KW_LEN[k]))) begin
        h.hit = 1'b1;
        h.idx = 3'(k);
      end
    end
    return h;
  endfunction

  function automatic cst_result_t make_res(cst_kind_t kind, logic [7:0] detail,
                                           logic [POS_BITS-1:0] start,
                                           logic [LEN_BITS-1:0] len);
    cst_result_t r;
    r.kind = kind;
    r.detail = detail;
    r.start_offset = START_BITS'(start);
    r.token_length = TLEN_BITS'(len);
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/cst_ifs.sv =====
// Valid/ready channel interfaces for source bytes and tokens.
`default_nettype none
interface cst_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       no_byte;
  logic       final_req;
  modport source (output valid, output ch, output no_byte, output final_req, input ready);
  modport sink (input valid, input ch, input no_byte, input final_req, output ready);
endinterface

interface cst_out_if;
  logic                            valid;
  logic                            ready;
  logic [2:0]                      kind;
  logic [7:0]                      detail;
  logic [cst_pkg::START_BITS-1:0]  start_offset;
  logic [cst_pkg::TLEN_BITS-1:0]   token_length;
  logic                            run_end;
  modport source (output valid, output kind, output detail, output start_offset,
                  output token_length, output run_end, input ready);
  modport sink (input valid, input kind, input detail, input start_offset,
                input token_length, input run_end, output ready);
endinterface
`default_nettype wire

// ===== hdl/cst_front.sv =====
// Front end: accepts source bytes, tracks scan state and builds token bundles.
`default_nettype none
module cst_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  cst_in_if.sink                     in_chan,
  input  wire cst_pkg::cst_q_stat_t  q_stat,
  output logic                       push,
  output cst_pkg::cst_bundle_t       push_bundle
);

  cst_pkg::cst_mode_t                    mode_r, mode_nxt;
  logic [cst_pkg::POS_BITS-1:0]          pos_r, pos_nxt;
  logic [cst_pkg::POS_BITS-1:0]          pstart_r, pstart_nxt;
  logic [cst_pkg::LEN_BITS-1:0]          plen_r, plen_nxt;
  logic [cst_pkg::KW_COUNT-1:0]          cand_r, cand_nxt;
  cst_pkg::cst_bundle_t                  bundle;
  logic                                  accept;

  always_comb begin
    logic [7:0]                   c;
    logic                         has_byte;
    logic                         done;
    logic [1:0]                   n;
    cst_pkg::cst_kw_hit_t         hit;
    c = in_chan.ch;
    has_byte = !in_chan.no_byte;
    done = 1'b0;
    n = 2'd0;
    hit = '0;
    bundle = '0;
    mode_nxt = mode_r;
    pos_nxt = pos_r;
    pstart_nxt = pstart_r;
    plen_nxt = plen_r;
    cand_nxt = cand_r;

    if (has_byte && (mode_nxt != cst_pkg::MODE_DROP)) begin
      case (mode_nxt)
        cst_pkg::MODE_NUM: begin
          if (cst_pkg::is_digit(c)) begin
            plen_nxt = cst_pkg::sat_inc(plen_nxt);
            done = 1'b1;
          end else if (cst_pkg::is_word_start(c)) begin
            bundle.res[n] = cst_pkg::make_res(cst_pkg::KIND_ERROR, cst_pkg::ERR_NUM_ALPHA,
                                              pstart_nxt, cst_pkg::sat_inc(plen_nxt));
            n = n + 2'd1;
            mode_nxt = cst_pkg::MODE_DROP;
            done = 1'b1;
          end else begin
            bundle.res[n] = cst_pkg::make_res(cst_pkg::KIND_NUMBER, 8'd0,
                                              pstart_nxt, plen_nxt);
            n = n + 2'd1;
            mode_nxt = cst_pkg::MODE_IDLE;
          end
        end
        cst_pkg::MODE_WORD: begin
          if (cst_pkg::is_word_char(c)) begin
            cand_nxt = cst_pkg::kw_match(cand_nxt, plen_nxt, c);
            plen_nxt = cst_pkg::sat_inc(plen_nxt);
            done = 1'b1;
          end else begin
            hit = cst_pkg::kw_close(cand_nxt, plen_nxt);
            if (hit.hit) begin
              bundle.res[n] = cst_pkg::make_res(cst_pkg::KIND_KEYWORD, 8'(hit.idx),
                                                pstart_nxt, plen_nxt);
              mode_nxt = cst_pkg::MODE_IDLE;
            end else begin
              bundle.res[n] = cst_pkg::make_res(cst_pkg::KIND_ERROR, cst_pkg::ERR_BAD_WORD,
                                                pstart_nxt, plen_nxt);
              mode_nxt = cst_pkg::MODE_DROP;
              done = 1'b1;
            end
            n = n + 2'd1;
          end
        end
        cst_pkg::MODE_STR: begin
          if (c == "\"") begin
            bundle.res[n] = cst_pkg::make_res(cst_pkg::KIND_STRING, 8'd0,
                                              pstart_nxt, plen_nxt);
            n = n + 2'd1;
            mode_nxt = cst_pkg::MODE_IDLE;
          end else begin
            plen_nxt = cst_pkg::sat_inc(plen_nxt);
          end
          done = 1'b1;
        end
        default: begin
        end
      endcase

      if (!done && (mode_nxt == cst_pkg::MODE_IDLE)) begin
        if (cst_pkg::is_space(c)) begin
        end else if (cst_pkg::is_digit(c)) begin
          mode_nxt = cst_pkg::MODE_NUM;
          pstart_nxt = pos_r;
          plen_nxt = cst_pkg::LEN_BITS'(1);
        end else if (cst_pkg::is_word_start(c)) begin
          mode_nxt = cst_pkg::MODE_WORD;
          pstart_nxt = pos_r;
          cand_nxt = cst_pkg::kw_match({cst_pkg::KW_COUNT{1'b1}}, '0, c);
          plen_nxt = cst_pkg::LEN_BITS'(1);
        end else if (c == "\"") begin
          mode_nxt = cst_pkg::MODE_STR;
          pstart_nxt = pos_r + cst_pkg::POS_BITS'(1);
          plen_nxt = '0;
        end else if (cst_pkg::is_op(c)) begin
          bundle.res[n] = cst_pkg::make_res(cst_pkg::KIND_OPERATOR, c, pos_r,
                                            cst_pkg::LEN_BITS'(1));
          n = n + 2'd1;
        end else if (cst_pkg::is_punct(c)) begin
          bundle.res[n] = cst_pkg::make_res(cst_pkg::KIND_PUNCT, c, pos_r,
                                            cst_pkg::LEN_BITS'(1));
          n = n + 2'd1;
        end else begin
          bundle.res[n] = cst_pkg::make_res(cst_pkg::KIND_ERROR, cst_pkg::ERR_BAD_CHAR,
                                            pos_r, cst_pkg::LEN_BITS'(1));
          n = n + 2'd1;
          mode_nxt = cst_pkg::MODE_DROP;
        end
      end
    end

    if (has_byte) begin
      pos_nxt = pos_r + cst_pkg::POS_BITS'(1);
    end

    if (in_chan.final_req) begin
      case (mode_nxt)
        cst_pkg::MODE_NUM: begin
          bundle.res[n] = cst_pkg::make_res(cst_pkg::KIND_NUMBER, 8'd0, pstart_nxt, plen_nxt);
          n = n + 2'd1;
          mode_nxt = cst_pkg::MODE_IDLE;
        end
        cst_pkg::MODE_WORD: begin
          hit = cst_pkg::kw_close(cand_nxt, plen_nxt);
          if (hit.hit) begin
            bundle.res[n] = cst_pkg::make_res(cst_pkg::KIND_KEYWORD, 8'(hit.idx),
                                              pstart_nxt, plen_nxt);
            mode_nxt = cst_pkg::MODE_IDLE;
          end else begin
            bundle.res[n] = cst_pkg::make_res(cst_pkg::KIND_ERROR, cst_pkg::ERR_BAD_WORD,
                                              pstart_nxt, plen_nxt);
            mode_nxt = cst_pkg::MODE_DROP;
          end
          n = n + 2'd1;
        end
        cst_pkg::MODE_STR: begin
          bundle.res[n] = cst_pkg::make_res(cst_pkg::KIND_ERROR, cst_pkg::ERR_OPEN_STRING,
                                            pstart_nxt, plen_nxt);
          n = n + 2'd1;
          mode_nxt = cst_pkg::MODE_DROP;
        end
        default: begin
        end
      endcase
      if (mode_nxt != cst_pkg::MODE_DROP) begin
        bundle.res[n] = cst_pkg::make_res(cst_pkg::KIND_END, 8'd0, pos_nxt, '0);
        n = n + 2'd1;
      end
      mode_nxt = cst_pkg::MODE_IDLE;
      pos_nxt = '0;
      pstart_nxt = '0;
      plen_nxt = '0;
      cand_nxt = {cst_pkg::KW_COUNT{1'b1}};
    end
    bundle.cnt = n;
  end

  always_comb begin
    in_chan.ready = !q_stat.full;
    accept = in_chan.valid && in_chan.ready;
    push = accept && (bundle.cnt != 2'd0);
    push_bundle = bundle;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= cst_pkg::MODE_IDLE;
      pos_r <= '0;
      pstart_r <= '0;
      plen_r <= '0;
      cand_r <= {cst_pkg::KW_COUNT{1'b1}};
    end else if (accept) begin
      mode_r <= mode_nxt;
      pos_r <= pos_nxt;
      pstart_r <= pstart_nxt;
      plen_r <= plen_nxt;
      cand_r <= cand_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/cst_queue.sv =====
// Two-entry queue of token bundles between the front and back ends.
`default_nettype none
module cst_queue (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire cst_pkg::cst_bundle_t  push_bundle,
  input  wire logic                  pop,
  output cst_pkg::cst_q_stat_t       q_stat,
  output cst_pkg::cst_bundle_t       head
);

  cst_pkg::cst_bundle_t mem_r [2];
  logic                 wr_ptr_r, wr_ptr_nxt;
  logic                 rd_ptr_r, rd_ptr_nxt;
  logic [1:0]           cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
    q_stat.full = (cnt_r == 2'd2);
    q_stat.empty = (cnt_r == 2'd0);
    head = mem_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/cst_back.sv =====
// Back end: sends the tokens of the head bundle one word at a time.
`default_nettype none
module cst_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cst_pkg::cst_bundle_t  head,
  input  wire cst_pkg::cst_q_stat_t  q_stat,
  output logic                       pop,
  cst_out_if.source                  out_chan
);

  logic [1:0]           idx_r, idx_nxt;
  logic                 last;
  logic                 fire;
  cst_pkg::cst_result_t cur;

  always_comb begin
    cur = head.res[idx_r];
    last = (idx_r == (head.cnt - 2'd1));
    out_chan.valid = !q_stat.empty;
    out_chan.kind = cur.kind;
    out_chan.detail = cur.detail;
    out_chan.start_offset = cur.start_offset;
    out_chan.token_length = cur.token_length;
    out_chan.run_end = last;
    fire = out_chan.valid && out_chan.ready;
    pop = fire && last;
    if (pop) begin
      idx_nxt = 2'd0;
    end else if (fire) begin
      idx_nxt = idx_r + 2'd1;
    end else begin
      idx_nxt = idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/c_subset_token_scanner.sv =====
// Top level of the token scanner: front end, bundle queue and back end.
`default_nettype none
// The scanner takes one source word per clock cycle and produces zero to three tokens
// for it; the tokens of one input word leave in order, one per output handshake, the
// last one flagged with run_end. A two-entry queue of token bundles decouples input and
// output, so input is accepted every cycle as long as each word yields at most one token
// on average; a word that yields several tokens holds the output port until its last one
// is sent, and the input stalls once two bundles are waiting. The bundle of an accepted
// word is registered in the queue before its first token is offered.
module c_subset_token_scanner (
  input  wire logic  clk,
  input  wire logic  rst_n,
  cst_in_if.sink     in_chan,
  cst_out_if.source  out_chan
);

  logic                 push;
  logic                 pop;
  cst_pkg::cst_bundle_t push_bundle;
  cst_pkg::cst_bundle_t head;
  cst_pkg::cst_q_stat_t q_stat;

  cst_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .q_stat      (q_stat),
    .push        (push),
    .push_bundle (push_bundle)
  );

  cst_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .push_bundle (push_bundle),
    .pop         (pop),
    .q_stat      (q_stat),
    .head        (head)
  );

  cst_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .q_stat   (q_stat),
    .pop      (pop),
    .out_chan (out_chan)
  );

  a_full_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !in_chan.ready)
    else $error("input accepted while the bundle queue is full");

  a_push_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (push_bundle.cnt != 2'd0))
    else $error("empty bundle pushed into the queue");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (out_chan.kind == cst_pkg::KIND_END)) |->
      (out_chan.run_end && (out_chan.token_length == 16'd0)))
    else $error("end token is not the last word of its bundle");

  a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (out_chan.run_end && !q_stat.empty))
    else $error("bundle popped before its last token was sent");

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for the C subset token scanner: directed table, then random sources.
module tb_top;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_WORDS = 296;
  localparam int DIR_ROWS = 24;
  localparam logic [7:0] QUOTE = 8'h22;

  typedef struct {
    cst_pkg::cst_kind_t kind;
    logic [7:0]         detail;
    logic [31:0]        start;
    logic [15:0]        len;
    bit                 last;
  } tok_t;

  typedef struct {
    logic [7:0]         ch;
    bit                 nb;
    bit                 fin;
    bit                 typed;
    cst_pkg::cst_kind_t kind;
    logic [7:0]         detail;
    logic [31:0]        start;
    logic [15:0]        len;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cst_in_if in_chan ();
  cst_out_if out_chan ();

  c_subset_token_scanner dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_chan),
    .out_chan(out_chan)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  string kw_names [6] = '{"int", "return", "if", "else", "while", "for"};

  cst_pkg::cst_mode_t sc_mode;
  logic [31:0] sc_pos;
  logic [31:0] sc_start;
  logic [15:0] sc_len;
  logic [5:0]  sc_cands;

  tok_t        fresh [$];
  tok_t        due_toks [$];
  stim_row_t   dir_rows [DIR_ROWS];
  logic [7:0]  src [$];

  bit calm = 1'b0;
  int errors = 0;
  int cycles = 0;
  int words_sent = 0;
  int sources = 0;
  int toks_seen = 0;
  int kind_seen [8];
  int stall_left = 0;

  function automatic bit digit_c(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit word_head(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit word_body(logic [7:0] c);
    return word_head(c) || digit_c(c);
  endfunction

  function automatic bit blank_c(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit op_c(logic [7:0] c);
    return c == "+" || c == "-" || c == "*" || c == "/" || c == "=" || c == "<" || c == ">";
  endfunction

  function automatic bit punct_c(logic [7:0] c);
    return c == ";" || c == "," || c == "(" || c == ")";
  endfunction

  function automatic logic [15:0] len_bump(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic void reset_scan();
    sc_mode = cst_pkg::MODE_IDLE;
    sc_pos = '0;
    sc_start = '0;
    sc_len = '0;
    sc_cands = 6'h3F;
  endfunction

  function automatic void emit_tok(cst_pkg::cst_kind_t k, logic [7:0] d, logic [31:0] s,
                                   logic [15:0] l);
    if (fresh.size() < cst_pkg::RES_SLOTS) fresh.insert(fresh.size(), tok_t'{k, d, s, l, 1'b0});
  endfunction

  function automatic void narrow_kw(logic [7:0] c);
    for (int k = 0; k < 6; k++) begin
      if (sc_len >= kw_names[k].len() || kw_names[k][sc_len] != c) sc_cands[k] = 1'b0;
    end
  endfunction

  function automatic void close_word();
    for (int k = 0; k < 6; k++) begin
      if (sc_cands[k] && sc_len == kw_names[k].len()) begin
        emit_tok(cst_pkg::KIND_KEYWORD, 8'(k), sc_start, sc_len);
        sc_mode = cst_pkg::MODE_IDLE;
        return;
      end
    end
    emit_tok(cst_pkg::KIND_ERROR, cst_pkg::ERR_BAD_WORD, sc_start, sc_len);
    sc_mode = cst_pkg::MODE_DROP;
  endfunction

  function automatic void open_token(logic [7:0] c);
    if (blank_c(c)) return;
    if (digit_c(c)) begin
      sc_mode = cst_pkg::MODE_NUM;
      sc_start = sc_pos;
      sc_len = 16'd1;
    end else if (word_head(c)) begin
      sc_mode = cst_pkg::MODE_WORD;
      sc_start = sc_pos;
      sc_len = 16'd0;
      sc_cands = 6'h3F;
      narrow_kw(c);
      sc_len = 16'd1;
    end else if (c == QUOTE) begin
      sc_mode = cst_pkg::MODE_STR;
      sc_start = sc_pos + 32'd1;
      sc_len = 16'd0;
    end else if (op_c(c)) begin
      emit_tok(cst_pkg::KIND_OPERATOR, c, sc_pos, 16'd1);
    end else if (punct_c(c)) begin
      emit_tok(cst_pkg::KIND_PUNCT, c, sc_pos, 16'd1);
    end else begin
      emit_tok(cst_pkg::KIND_ERROR, cst_pkg::ERR_BAD_CHAR, sc_pos, 16'd1);
      sc_mode = cst_pkg::MODE_DROP;
    end
  endfunction

  function automatic void predict_scan(logic [7:0] c, bit nb, bit fin);
    bit done;
    fresh.delete();
    if (!nb && sc_mode != cst_pkg::MODE_DROP) begin
      done = 1'b0;
      case (sc_mode)
        cst_pkg::MODE_NUM: begin
          if (digit_c(c)) begin
            sc_len = len_bump(sc_len);
            done = 1'b1;
          end else if (word_head(c)) begin
            emit_tok(cst_pkg::KIND_ERROR, cst_pkg::ERR_NUM_ALPHA, sc_start, len_bump(sc_len));
            sc_mode = cst_pkg::MODE_DROP;
            done = 1'b1;
          end else begin
            emit_tok(cst_pkg::KIND_NUMBER, 8'd0, sc_start, sc_len);
            sc_mode = cst_pkg::MODE_IDLE;
          end
        end
        cst_pkg::MODE_WORD: begin
          if (word_body(c)) begin
            narrow_kw(c);
            sc_len = len_bump(sc_len);
            done = 1'b1;
          end else begin
            close_word();
            if (sc_mode == cst_pkg::MODE_DROP) done = 1'b1;
          end
        end
        cst_pkg::MODE_STR: begin
          if (c == QUOTE) begin
            emit_tok(cst_pkg::KIND_STRING, 8'd0, sc_start, sc_len);
            sc_mode = cst_pkg::MODE_IDLE;
          end else begin
            sc_len = len_bump(sc_len);
          end
          done = 1'b1;
        end
        default: ;
      endcase
      if (!done && sc_mode == cst_pkg::MODE_IDLE) open_token(c);
    end
    if (!nb) sc_pos = sc_pos + 32'd1;
    if (fin) begin
      if (sc_mode == cst_pkg::MODE_NUM) begin
        emit_tok(cst_pkg::KIND_NUMBER, 8'd0, sc_start, sc_len);
        sc_mode = cst_pkg::MODE_IDLE;
      end else if (sc_mode == cst_pkg::MODE_WORD) begin
        close_word();
      end else if (sc_mode == cst_pkg::MODE_STR) begin
        emit_tok(cst_pkg::KIND_ERROR, cst_pkg::ERR_OPEN_STRING, sc_start, sc_len);
        sc_mode = cst_pkg::MODE_DROP;
      end
      if (sc_mode != cst_pkg::MODE_DROP) emit_tok(cst_pkg::KIND_END, 8'd0, sc_pos, 16'd0);
      reset_scan();
    end
    if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic stim_row_t plain_row(logic [7:0] c, bit nb, bit fin);
    return stim_row_t'{c, nb, fin, 1'b0, cst_pkg::KIND_KEYWORD, 8'd0, 32'd0, 16'd0};
  endfunction

  function automatic stim_row_t typed_row(logic [7:0] c, bit nb, bit fin,
                                          cst_pkg::cst_kind_t k, logic [7:0] d,
                                          logic [31:0] s, logic [15:0] l);
    return stim_row_t'{c, nb, fin, 1'b1, k, d, s, l};
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  task automatic send_word(input stim_row_t row);
    int gap;
    in_chan.valid <= 1'b1;
    in_chan.ch <= row.ch;
    in_chan.no_byte <= row.nb;
    in_chan.final_req <= row.fin;
    do @(posedge clk); while (!in_chan.ready);
    predict_scan(row.ch, row.nb, row.fin);
    if (row.typed) begin
      fresh.delete();
      fresh.insert(0, tok_t'{row.kind, row.detail, row.start, row.len, 1'b1});
    end
    foreach (fresh[i]) due_toks.insert(due_toks.size(), fresh[i]);
    words_sent++;
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic hold_off();
    in_chan.valid <= 1'b0;
    do @(negedge clk); while (due_toks.size() != 0);
  endtask

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == QUOTE);
    return b;
  endfunction

  function automatic logic [7:0] pick_head();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    return "_";
  endfunction

  function automatic logic [7:0] pick_body();
    int r;
    r = $urandom_range(0, 62);
    if (r < 10) return 8'("0" + r);
    return pick_head();
  endfunction

  function automatic void put_src(logic [7:0] b);
    src.insert(src.size(), b);
  endfunction

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) put_src(s[i]);
  endtask

  task automatic add_blanks();
    int n;
    int r;
    n = $urandom_range(1, 3);
    repeat (n) begin
      r = $urandom_range(0, 5);
      put_src(r == 0 ? 8'h20 : 8'(8 + r));
    end
  endtask

  task automatic add_fault();
    int f;
    int n;
    string s;
    logic [7:0] b;
    add_blanks();
    f = $urandom_range(0, 3);
    case (f)
      0: begin
        s = kw_names[$urandom_range(0, 5)];
        n = $urandom_range(0, 2);
        if (n == 0) begin
          push_text(s.substr(0, s.len() - 2));
        end else if (n == 1) begin
          push_text(s);
          put_src(pick_body());
        end else begin
          put_src(pick_head());
          repeat ($urandom_range(0, 5)) put_src(pick_body());
        end
      end
      1: begin
        repeat ($urandom_range(1, 3)) put_src(8'("0" + $urandom_range(0, 9)));
        put_src(pick_head());
      end
      2: begin
        do b = 8'($urandom);
        while (digit_c(b) || word_head(b) || blank_c(b) || op_c(b) || punct_c(b) || b == QUOTE);
        put_src(b);
      end
      default: begin
        put_src(QUOTE);
        repeat ($urandom_range(0, 5)) put_src(text_byte());
      end
    endcase
    if (f != 3) repeat ($urandom_range(0, 3)) put_src(8'($urandom));
  endtask

  task automatic build_source();
    int r;
    int ntok;
    int pick;
    bit sep_needed;
    string glyphs;
    src.delete();
    r = $urandom_range(0, 9);
    if (r == 0) begin
      repeat ($urandom_range(1, 12)) put_src(8'($urandom));
      return;
    end
    ntok = $urandom_range(1, 8);
    sep_needed = 1'b0;
    for (int t = 0; t < ntok; t++) begin
      if (sep_needed || $urandom_range(0, 1) == 1) add_blanks();
      pick = $urandom_range(0, 5);
      sep_needed = (pick == 0 || pick == 1 || pick == 5);
      case (pick)
        1: repeat ($urandom_range(1, 5)) put_src(8'("0" + $urandom_range(0, 9)));
        2: begin
          glyphs = "+-*/=<>";
          put_src(glyphs[$urandom_range(0, 6)]);
        end
        3: begin
          glyphs = ";,()";
          put_src(glyphs[$urandom_range(0, 3)]);
        end
        4: begin
          put_src(QUOTE);
          repeat ($urandom_range(0, 6)) put_src(text_byte());
          put_src(QUOTE);
        end
        default: push_text(kw_names[$urandom_range(0, 5)]);
      endcase
    end
    if (r <= 3) add_fault();
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= 1'b1;
      if ($urandom_range(0, 2) == 0) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    tok_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      toks_seen++;
      kind_seen[out_chan.kind]++;
      if (due_toks.size() == 0) begin
        $error("token with nothing expected: kind %0d detail %0d offset %0d length %0d",
               out_chan.kind, out_chan.detail, out_chan.start_offset, out_chan.token_length);
        errors++;
      end else begin
        want = due_toks.pop_front();
        check_field("kind", 32'(want.kind), 32'(out_chan.kind));
        check_field("detail", 32'(want.detail), 32'(out_chan.detail));
        check_field("start_offset", want.start, out_chan.start_offset);
        check_field("token_length", 32'(want.len), 32'(out_chan.token_length));
        check_field("run_end", 32'(want.last), 32'(out_chan.run_end));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("c_subset_token_scanner verification failed");
      $finish;
    end
  end

  initial begin
    int rand_words;
    bit fin_on_byte;
    in_chan.valid = 1'b0;
    in_chan.ch = 8'd0;
    in_chan.no_byte = 1'b0;
    in_chan.final_req = 1'b0;
    out_chan.ready = 1'b0;
    foreach (kind_seen[i]) kind_seen[i] = 0;
    reset_scan();

    dir_rows = '{
      typed_row(8'hFF, 1'b0, 1'b0, cst_pkg::KIND_ERROR, cst_pkg::ERR_BAD_CHAR, 32'd0, 16'd1),
      plain_row(8'hAA, 1'b1, 1'b1),
      typed_row(8'h00, 1'b1, 1'b1, cst_pkg::KIND_END, 8'd0, 32'd0, 16'd0),
      plain_row(8'h55, 1'b1, 1'b0),
      typed_row("+", 1'b0, 1'b0, cst_pkg::KIND_OPERATOR, "+", 32'd0, 16'd1),
      typed_row(";", 1'b0, 1'b0, cst_pkg::KIND_PUNCT, ";", 32'd1, 16'd1),
      plain_row(" ", 1'b0, 1'b0),
      plain_row("i", 1'b0, 1'b0),
      plain_row("n", 1'b0, 1'b0),
      plain_row("t", 1'b0, 1'b0),
      plain_row(8'h09, 1'b0, 1'b0),
      plain_row("1", 1'b0, 1'b0),
      plain_row("2", 1'b0, 1'b0),
      plain_row("(", 1'b0, 1'b0),
      plain_row(QUOTE, 1'b0, 1'b0),
      plain_row("a", 1'b0, 1'b0),
      plain_row(QUOTE, 1'b0, 1'b0),
      plain_row("i", 1'b0, 1'b0),
      plain_row("f", 1'b0, 1'b1),
      plain_row("7", 1'b0, 1'b0),
      typed_row("x", 1'b0, 1'b1, cst_pkg::KIND_ERROR, cst_pkg::ERR_NUM_ALPHA, 32'd0, 16'd2),
      typed_row(8'h00, 1'b0, 1'b1, cst_pkg::KIND_ERROR, cst_pkg::ERR_BAD_CHAR, 32'd0, 16'd1),
      typed_row("x", 1'b0, 1'b1, cst_pkg::KIND_ERROR, cst_pkg::ERR_BAD_WORD, 32'd0, 16'd1),
      typed_row(QUOTE, 1'b0, 1'b1, cst_pkg::KIND_ERROR, cst_pkg::ERR_OPEN_STRING, 32'd1,
                16'd0)
    };

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_word(dir_rows[i]);

    rand_words = 0;
    while (rand_words < RANDOM_WORDS) begin
      calm = ($urandom_range(0, 4) == 0);
      build_source();
      fin_on_byte = $urandom_range(0, 1);
      foreach (src[i]) begin
        if ($urandom_range(0, 19) == 0) send_word(plain_row(8'($urandom), 1'b1, 1'b0));
        send_word(plain_row(src[i], 1'b0, fin_on_byte && i == src.size() - 1));
        rand_words++;
      end
      if (!fin_on_byte) begin
        send_word(plain_row(8'($urandom), 1'b1, 1'b1));
        rand_words++;
      end
      sources++;
      if (sources == 1 || $urandom_range(0, 5) == 0) hold_off();
    end
    in_chan.valid <= 1'b0;

    while (due_toks.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Sent %0d words (directed table plus %0d random sources), checked %0d tokens.",
             words_sent, sources, toks_seen);
    $display("Tokens: keyword %0d, number %0d, operator %0d, punct %0d, string %0d, %s",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4],
             $sformatf("end %0d, error %0d.", kind_seen[5], kind_seen[6]));
    if (errors == 0) begin
      $display("c_subset_token_scanner verification clean");
    end else begin
      $display("c_subset_token_scanner verification failed");
    end
    $finish;
  end

endmodule
